[rtl/swkj_pkg.sv]
`timescale 1ns / 1ps
package swkj_pkg;

  localparam int unsigned AmtW  = 40;
  localparam int unsigned TimeW = 48;
  localparam int unsigned SumW  = 48;
  localparam int unsigned CntW  = 32;
  localparam int unsigned KeyW  = 6;
  localparam int unsigned OpW   = 2;

  typedef enum logic [OpW-1:0] {
    OP_AD   = 2'd0,
    OP_CHK  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // one bank entry for both streams
  typedef struct packed {
    logic             ad_seen;
    logic [SumW-1:0]  ad_cost;
    logic [TimeW-1:0] ad_evt;
    logic [TimeW-1:0] ad_prc;
    logic [CntW-1:0]  ad_cnt;
    logic             chk_seen;
    logic [SumW-1:0]  chk_val;
    logic [TimeW-1:0] chk_evt;
    logic [TimeW-1:0] chk_prc;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EV_RD,
    ST_EV_WR,
    ST_TK_RD,
    ST_TK_ACC,
    ST_TK_EMIT,
    ST_TK_WAIT,
    ST_TK_NONE,
    ST_TK_FLUSH,
    ST_TK_CLR
  } state_e;

  function automatic logic [SumW-1:0] sat_add48(logic [SumW-1:0] a, logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
  endfunction

  function automatic logic [CntW-1:0] sat_add32(logic [CntW-1:0] a, logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
  endfunction

  function automatic logic [TimeW-1:0] max48(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

[rtl/swkj_ram.sv]
`timescale 1ns / 1ps
module swkj_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // single write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/sliding_window_keyed_join.sv]
`timescale 1ns / 1ps
// events: read, modify and write back of one bank entry per item
// ticks: per key, a read and an accumulate state per window slide plus the emit and
//   wait states, then a state for the final item and a clear of all KEYS entries of the
//   oldest bank; the walk is held up while the output stalls
// reset: asynchronous active low, followed by a clearing pass over all
//   2**($clog2(SLIDES)+$clog2(KEYS)) entries (512 by default) of the bank memory,
//   during which no item is accepted
module sliding_window_keyed_join #(
  parameter int unsigned KEYS   = 64,
  parameter int unsigned SLIDES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [3:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[1:0], ad_id[7:2], amount[47:8], event_time[95:48], timestamp[143:96]
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // key_out[5:0], profit[54:6], max_event_time[102:55], max_proc_time[150:103],
  // emit_time[198:151], ad_count[230:199], zero fill
  output logic [231:0] m_axis_tdata,
  // joined
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);
  import swkj_pkg::*;

  localparam int unsigned KIW   = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int unsigned SIW   = (SLIDES > 1) ? $clog2(SLIDES) : 1;
  localparam int unsigned Depth = (2 ** SIW) * (2 ** KIW);
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CLW   = AW + 1;

  // input fields
  logic [OpW-1:0]   in_op;
  logic [KeyW-1:0]  in_key;
  logic [AmtW-1:0]  in_amt;
  logic [TimeW-1:0] in_et;
  logic [TimeW-1:0] in_ts;
  assign in_op  = s_axis_tdata[1:0];
  assign in_key = s_axis_tdata[7:2];
  assign in_amt = s_axis_tdata[47:8];
  assign in_et  = s_axis_tdata[95:48];
  assign in_ts  = s_axis_tdata[143:96];

  state_e state_q, state_d;
  logic [3:0]       win_q;
  logic [SIW-1:0]   cur_q, cur_d;
  logic [CLW-1:0]   clr_q, clr_d;
  logic [KIW:0]     key_q, key_d;
  logic [3:0]       sl_q, sl_d;
  logic             any_q, any_d;
  logic [OpW-1:0]   op_q, op_d;
  logic [KIW-1:0]   ekey_q, ekey_d;
  logic [AmtW-1:0]  amt_q, amt_d;
  logic [TimeW-1:0] et_q, et_d;
  logic [TimeW-1:0] ts_q, ts_d;

  // window accumulators
  logic             sa_q, sa_d, sc_q, sc_d;
  logic [SumW-1:0]  cost_q, cost_d, val_q, val_d;
  logic [TimeW-1:0] evt_q, evt_d, prc_q, prc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  // pending joined result, held until the next match or key walk end
  logic             pv_q, pv_d;
  logic [231:0]     pdata_q, pdata_d;

  // output register
  logic             ov_q, ov_d, ou_q, ou_d, ol_q, ol_d;
  logic [231:0]     od_q, od_d;

  logic             ram_we;
  logic [AW-1:0]    ram_wa, ram_ra;
  entry_t           ram_wd, ram_rd;
  logic [EntryW-1:0] ram_rd_bits;
  assign ram_rd = entry_t'(ram_rd_bits);

  swkj_ram #(.Width(EntryW), .Depth(Depth)) u_bank_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd_bits)
  );

  // effective window and slide indexing
  logic [3:0] win_eff;
  always_comb begin
    win_eff = win_q;
    if (win_eff == 4'd0) win_eff = 4'd1;
    if (32'(win_eff) > SLIDES) win_eff = 4'(SLIDES);
  end

  logic [SIW-1:0] bank_sel;
  logic [SIW:0]   bank_tmp;
  always_comb begin
    bank_tmp = {1'b0, cur_q} + (SIW+1)'(SLIDES) - (SIW+1)'(sl_q);
    if (32'(bank_tmp) >= SLIDES) bank_tmp = bank_tmp - (SIW+1)'(SLIDES);
    bank_sel = bank_tmp[SIW-1:0];
  end

  logic [SIW-1:0] cur_next;
  assign cur_next = (32'(cur_q) == SLIDES - 1) ? '0 : cur_q + 1'b1;

  logic out_free;
  assign out_free = !ov_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (32'(clr_q) == Depth - 1) state_d = ST_IDLE;
      ST_IDLE:     if (s_axis_tvalid) begin
                     if (in_op == OP_TICK) state_d = ST_TK_RD;
                     else if ((in_op == OP_AD || in_op == OP_CHK) &&
                              32'(in_key) < KEYS &&
                              !(in_op == OP_CHK && in_key == '0))
                       state_d = ST_EV_RD;
                   end
      ST_EV_RD:    state_d = ST_EV_WR;
      ST_EV_WR:    state_d = ST_IDLE;
      ST_TK_RD:    state_d = ST_TK_ACC;
      ST_TK_ACC:   state_d = (sl_q + 1'b1 == win_eff) ? ST_TK_EMIT : ST_TK_RD;
      ST_TK_EMIT:  state_d = ST_TK_WAIT;
      ST_TK_WAIT:  if (32'(key_q) == KEYS - 1) state_d = any_d ? ST_TK_FLUSH : ST_TK_NONE;
                   else state_d = ST_TK_RD;
      ST_TK_NONE:  if (out_free) state_d = ST_TK_CLR;
      ST_TK_FLUSH: if (out_free) state_d = ST_TK_CLR;
      ST_TK_CLR:   if (32'(clr_q) == KEYS - 1) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    entry_t e;
    logic [231:0] res;
    cur_d = cur_q; clr_d = clr_q; key_d = key_q; sl_d = sl_q; any_d = any_q;
    op_d = op_q; ekey_d = ekey_q; amt_d = amt_q; et_d = et_q; ts_d = ts_q;
    sa_d = sa_q; sc_d = sc_q; cost_d = cost_q; val_d = val_q;
    evt_d = evt_q; prc_d = prc_q; cnt_d = cnt_q;
    pv_d = pv_q; pdata_d = pdata_q;
    ov_d = ov_q; ou_d = ou_q; ol_d = ol_q; od_d = od_q;
    ram_we = 1'b0; ram_wa = '0; ram_wd = '0; ram_ra = '0;
    s_axis_tready = 1'b0;
    e = ram_rd;
    res = '0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1; ram_wa = clr_q[AW-1:0];
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == Depth - 1) clr_d = '0;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        op_d = in_op; ekey_d = in_key[KIW-1:0]; amt_d = in_amt;
        et_d = in_et; ts_d = in_ts;
        key_d = '0; sl_d = '0; any_d = 1'b0; pv_d = 1'b0;
        sa_d = 1'b0; sc_d = 1'b0; cost_d = '0; val_d = '0;
        evt_d = '0; prc_d = '0; cnt_d = '0;
        ram_ra = {cur_q, in_key[KIW-1:0]};
      end
      // keep the entry address so the read data holds into the write cycle
      ST_EV_RD: ram_ra = {cur_q, ekey_q};
      ST_EV_WR: begin
        if (op_q == OP_AD) begin
          e.ad_seen = 1'b1;
          e.ad_cost = sat_add48(e.ad_cost, SumW'(amt_q));
          e.ad_evt  = max48(e.ad_evt, et_q);
          e.ad_prc  = max48(e.ad_prc, ts_q);
          e.ad_cnt  = sat_add32(e.ad_cnt, CntW'(1));
        end else begin
          e.chk_seen = 1'b1;
          e.chk_val  = sat_add48(e.chk_val, SumW'(amt_q));
          e.chk_evt  = max48(e.chk_evt, et_q);
          e.chk_prc  = max48(e.chk_prc, ts_q);
        end
        ram_we = 1'b1; ram_wa = {cur_q, ekey_q}; ram_wd = e;
      end
      ST_TK_RD: ram_ra = {bank_sel, key_q[KIW-1:0]};
      ST_TK_ACC: begin
        if (e.ad_seen) begin
          sa_d = 1'b1;
          cost_d = sat_add48(cost_q, e.ad_cost);
          cnt_d  = sat_add32(cnt_q, e.ad_cnt);
        end
        if (e.chk_seen) begin
          sc_d = 1'b1;
          val_d = sat_add48(val_q, e.chk_val);
        end
        evt_d = max48(evt_q, max48(e.ad_seen ? e.ad_evt : '0, e.chk_seen ? e.chk_evt : '0));
        prc_d = max48(prc_q, max48(e.ad_seen ? e.ad_prc : '0, e.chk_seen ? e.chk_prc : '0));
        sl_d = sl_q + 1'b1;
      end
      ST_TK_EMIT: begin
        // a match forms the joined result; the wait state pushes out the previous pending one
        if (sa_q && sc_q) begin
          res = {1'b0, cnt_q, ts_q, prc_q, evt_q,
                 49'({1'b0, val_q} - {1'b0, cost_q}), 6'(key_q[KIW-1:0])};
        end
      end
      ST_TK_WAIT: begin
        if (sa_q && sc_q) begin
          res = {1'b0, cnt_q, ts_q, prc_q, evt_q,
                 49'({1'b0, val_q} - {1'b0, cost_q}), 6'(key_q[KIW-1:0])};
          if (!pv_q) begin
            pv_d = 1'b1; pdata_d = res; any_d = 1'b1; sa_d = 1'b0;
          end else if (out_free) begin
            ov_d = 1'b1; ou_d = 1'b1; ol_d = 1'b0; od_d = pdata_q;
            pdata_d = res; sa_d = 1'b0;
          end
        end
        if (!(sa_q && sc_q) || !pv_q || out_free) begin
          sl_d = '0; key_d = key_q + 1'b1;
          sa_d = 1'b0; sc_d = 1'b0; cost_d = '0; val_d = '0;
          evt_d = '0; prc_d = '0; cnt_d = '0;
        end
      end
      ST_TK_NONE: if (out_free) begin
        ov_d = 1'b1; ou_d = 1'b0; ol_d = 1'b1;
        od_d = '0; od_d[198:151] = ts_q;
        cur_d = cur_next;
      end
      ST_TK_FLUSH: if (out_free) begin
        ov_d = 1'b1; ou_d = 1'b1; ol_d = 1'b1; od_d = pdata_q;
        pv_d = 1'b0;
        cur_d = cur_next;
      end
      ST_TK_CLR: begin
        ram_we = 1'b1; ram_wa = {cur_q, clr_q[KIW-1:0]};
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == KEYS - 1) clr_d = '0;
      end
      default: ;
    endcase
  end

  // wait state stalls when a second match meets a full output
  state_e state_n;
  always_comb begin
    state_n = state_d;
    if (state_q == ST_TK_WAIT && sa_q && sc_q && pv_q && !out_free) state_n = ST_TK_WAIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      win_q <= 4'd5; cur_q <= '0; clr_q <= '0; key_q <= '0; sl_q <= '0;
      any_q <= 1'b0; pv_q <= 1'b0; ov_q <= 1'b0;
      sa_q <= 1'b0; sc_q <= 1'b0;
    end else begin
      state_q <= state_n;
      if (cfg_we_i) win_q <= cfg_wdata_i;
      cur_q <= cur_d; clr_q <= clr_d; key_q <= key_d; sl_q <= sl_d;
      any_q <= any_d; pv_q <= pv_d; ov_q <= ov_d;
      sa_q <= sa_d; sc_q <= sc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; ekey_q <= ekey_d; amt_q <= amt_d; et_q <= et_d; ts_q <= ts_d;
    cost_q <= cost_d; val_q <= val_d; evt_q <= evt_d; prc_q <= prc_d; cnt_q <= cnt_d;
    pdata_q <= pdata_d; ou_q <= ou_d; ol_q <= ol_d; od_q <= od_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;
  assign m_axis_tlast  = ol_q;

  // no item taken during the clearing pass
  a_no_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("item accepted while clearing");

  // an unjoined marker always ends a tick
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
    else $error("unjoined marker without last");

  // the bank pointer only moves at the end of a tick
  a_cur_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q != $past(cur_q)) |-> ($past(state_q) == ST_TK_NONE ||
                                 $past(state_q) == ST_TK_FLUSH))
    else $error("bank pointer moved outside tick end");

endmodule
